@@ rtl/msk_pkg.sv @@
// Shared types and constants for the Morse symbol keyer.
// Holds the character pattern table and the timing register layout.
// No dependencies.
package msk_pkg;

  localparam int TABLE_SIZE = 38;
  localparam int TICK_W     = 16;
  localparam int SYM_W      = 6;
  localparam int CFG_IDX_W  = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DOT        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DASH       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ELEM_GAP   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LETTER_GAP = 2'd3;

  localparam logic [TICK_W-1:0] DOT_RESET        = 16'd200;
  localparam logic [TICK_W-1:0] DASH_RESET       = 16'd600;
  localparam logic [TICK_W-1:0] ELEM_GAP_RESET   = 16'd200;
  localparam logic [TICK_W-1:0] LETTER_GAP_RESET = 16'd600;

  typedef struct packed {
    logic [2:0] len;   // number of elements
    logic [7:0] dash;  // bit i set: element i is a dash
  } sym_entry_t;

  typedef struct packed {
    logic [TICK_W-1:0] dot;
    logic [TICK_W-1:0] dash;
    logic [TICK_W-1:0] elem_gap;
    logic [TICK_W-1:0] letter_gap;
  } timing_t;

  localparam sym_entry_t CODE_TABLE [TABLE_SIZE] = '{
    '{3'd2, 8'h02}, '{3'd4, 8'h01}, '{3'd3, 8'h06}, '{3'd3, 8'h01},
    '{3'd1, 8'h00}, '{3'd4, 8'h04}, '{3'd3, 8'h03}, '{3'd4, 8'h00},
    '{3'd2, 8'h00}, '{3'd4, 8'h0E}, '{3'd3, 8'h05}, '{3'd4, 8'h02},
    '{3'd2, 8'h03}, '{3'd2, 8'h01}, '{3'd3, 8'h07}, '{3'd4, 8'h06},
    '{3'd4, 8'h0B}, '{3'd3, 8'h02}, '{3'd3, 8'h00}, '{3'd1, 8'h01},
    '{3'd3, 8'h04}, '{3'd4, 8'h04}, '{3'd4, 8'h08}, '{3'd3, 8'h06},
    '{3'd4, 8'h09}, '{3'd4, 8'h0D}, '{3'd4, 8'h03}, '{3'd4, 8'h0A},
    '{3'd4, 8'h05}, '{3'd4, 8'h07}, '{3'd4, 8'h03}, '{3'd5, 8'h04},
    '{3'd6, 8'h00}, '{3'd6, 8'h0C}, '{3'd6, 8'h35}, '{3'd5, 8'h09},
    '{3'd5, 8'h0D}, '{3'd6, 8'h2D}
  };

endpackage

@@ rtl/morse_symbol_keyer.sv @@
// Top level of the Morse symbol keyer: timing registers and wiring.
// Depends on msk_pkg, msk_front, msk_fifo and msk_back.
//
// A character is given as its position (0 to 37) in the keyer's character
// set and is transferred at a clock edge where start is high and busy is
// low. For a pattern of N elements (N at most MAX_ELEMENTS, six in the
// table) the keyer produces 2N+1 runs: a key-on run of dot or dash length
// and a key-off element gap per element, then a key-off letter gap marked
// by out_last_run. Each run appears for exactly one cycle with out_strobe
// high and must be taken in that cycle, as the receiver has no way to hold
// results back. Runs come out one per cycle while a character is in
// progress; when the keyer is idle, a character goes through the queue and
// the state register to the output registers. The sequencer picks up
// the next queued character during a letter gap, so back-to-back characters
// produce an unbroken stream of runs. A two-entry queue sits between the
// lookup and the sequencer; busy is high while it is full. Positions outside
// the set are accepted and produce no runs. The four timing registers
// (dot, dash, element gap, letter gap) are written through the cfg_ port,
// which is always ready; they should only be changed while the keyer is
// idle. They reset to 200, 600, 200 and 600 ticks.
module morse_symbol_keyer #(
  parameter int SYMBOL_COUNT = 38,
  parameter int MAX_ELEMENTS = 6
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [msk_pkg::SYM_W-1:0]      in_symbol_index,
  output logic                           out_strobe,
  output logic                           out_key_level,
  output logic [msk_pkg::TICK_W-1:0]     out_run_ticks,
  output logic                           out_last_run,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [msk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msk_pkg::TICK_W-1:0]     cfg_data
);

  // Width of an element count, able to hold MAX_ELEMENTS itself.
  localparam int LEN_W = $clog2(MAX_ELEMENTS + 1);
  localparam int QW    = LEN_W + MAX_ELEMENTS;

  msk_pkg::timing_t timing_r;
  logic             accept;
  logic             push;
  logic [QW-1:0]    push_data;
  logic             pop;
  logic [QW-1:0]    pop_data;
  logic             q_empty;
  logic             q_full;

  // The register file takes a write in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.dot        <= msk_pkg::DOT_RESET;
      timing_r.dash       <= msk_pkg::DASH_RESET;
      timing_r.elem_gap   <= msk_pkg::ELEM_GAP_RESET;
      timing_r.letter_gap <= msk_pkg::LETTER_GAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        msk_pkg::REG_DOT:        timing_r.dot        <= cfg_data;
        msk_pkg::REG_DASH:       timing_r.dash       <= cfg_data;
        msk_pkg::REG_ELEM_GAP:   timing_r.elem_gap   <= cfg_data;
        msk_pkg::REG_LETTER_GAP: timing_r.letter_gap <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // A transfer is refused only while the queue has no free entry.
  assign busy   = q_full;
  assign accept = start && !busy;

  msk_front #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LEN_W        (LEN_W)
  ) u_front (
    .accept       (accept),
    .symbol_index (in_symbol_index),
    .push         (push),
    .push_data    (push_data)
  );

  msk_fifo #(
    .W (QW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  msk_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LEN_W        (LEN_W)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .timing        (timing_r),
    .q_empty       (q_empty),
    .q_data        (pop_data),
    .q_pop         (pop),
    .out_strobe    (out_strobe),
    .out_key_level (out_key_level),
    .out_run_ticks (out_run_ticks),
    .out_last_run  (out_last_run)
  );

endmodule

@@ rtl/msk_front.sv @@
// Front end of the Morse symbol keyer: range check and pattern lookup.
// Uses msk_pkg for the character table; feeds msk_fifo.
module msk_front #(
  parameter int SYMBOL_COUNT = 38,
  parameter int MAX_ELEMENTS = 6,
  parameter int LEN_W        = 3
) (
  input  logic                          accept,
  input  logic [msk_pkg::SYM_W-1:0]     symbol_index,
  output logic                          push,
  output logic [LEN_W+MAX_ELEMENTS-1:0] push_data
);

  msk_pkg::sym_entry_t entry;
  logic                in_set;
  logic [3:0]          len_full;
  logic [3:0]          len_clamped;

  always_comb begin
    in_set = ({1'b0, symbol_index} < 7'(msk_pkg::TABLE_SIZE)) &&
             ({1'b0, symbol_index} < 7'(SYMBOL_COUNT));
    entry  = msk_pkg::CODE_TABLE[symbol_index];
    len_full = {1'b0, entry.len};
    if (len_full > 4'(MAX_ELEMENTS)) begin
      len_clamped = 4'(MAX_ELEMENTS);
    end else begin
      len_clamped = len_full;
    end
    // Characters outside the set are dropped here and never reach the queue.
    push      = accept && in_set;
    push_data = {LEN_W'(len_clamped), MAX_ELEMENTS'(entry.dash)};
  end

endmodule

@@ rtl/msk_fifo.sv @@
// Two-entry queue between the front and back ends of the keyer.
// No package dependencies.
module msk_fifo #(
  parameter int W = 9
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty,
  output logic         full
);

  logic [W-1:0] mem [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  assign pop_data = mem[rd_ptr_r];
  assign empty    = (count_r == 2'd0);
  assign full     = (count_r == 2'd2);

endmodule

@@ rtl/msk_back.sv @@
// Back end of the keyer: steps through one pattern and emits timed runs.
// Uses msk_pkg for the timing register layout; fed by msk_fifo.
module msk_back #(
  parameter int MAX_ELEMENTS = 6,
  parameter int LEN_W        = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  msk_pkg::timing_t              timing,
  input  logic                          q_empty,
  input  logic [LEN_W+MAX_ELEMENTS-1:0] q_data,
  output logic                          q_pop,
  output logic                          out_strobe,
  output logic                          out_key_level,
  output logic [msk_pkg::TICK_W-1:0]    out_run_ticks,
  output logic                          out_last_run
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEY_ON,
    ST_KEY_OFF,
    ST_LETTER_GAP
  } state_t;

  state_t                       state_r, state_nxt;
  logic [LEN_W-1:0]             len_r, len_nxt;
  logic [LEN_W-1:0]             elem_r, elem_nxt;
  logic [MAX_ELEMENTS-1:0]      dash_r, dash_nxt;
  logic                         strobe_nxt;
  logic                         level_nxt;
  logic [msk_pkg::TICK_W-1:0]   ticks_nxt;
  logic                         last_nxt;
  logic                         load;
  logic [LEN_W-1:0]             q_len;
  logic [MAX_ELEMENTS-1:0]      q_dash;
  logic                         out_strobe_r, out_key_level_r, out_last_run_r;
  logic [msk_pkg::TICK_W-1:0]   out_run_ticks_r;

  assign q_len  = q_data[LEN_W+MAX_ELEMENTS-1:MAX_ELEMENTS];
  assign q_dash = q_data[MAX_ELEMENTS-1:0];

  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    elem_nxt   = elem_r;
    dash_nxt   = dash_r;
    strobe_nxt = 1'b0;
    level_nxt  = 1'b0;
    ticks_nxt  = timing.letter_gap;
    last_nxt   = 1'b0;
    load       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        load = !q_empty;
      end
      ST_KEY_ON: begin
        strobe_nxt = 1'b1;
        level_nxt  = 1'b1;
        ticks_nxt  = dash_r[0] ? timing.dash : timing.dot;
        dash_nxt   = dash_r >> 1;
        state_nxt  = ST_KEY_OFF;
      end
      ST_KEY_OFF: begin
        strobe_nxt = 1'b1;
        ticks_nxt  = timing.elem_gap;
        elem_nxt   = elem_r + LEN_W'(1);
        state_nxt  = (elem_nxt == len_r) ? ST_LETTER_GAP : ST_KEY_ON;
      end
      ST_LETTER_GAP: begin
        strobe_nxt = 1'b1;
        last_nxt   = 1'b1;
        state_nxt  = ST_IDLE;
        // Pick up the next character straight away so runs stay contiguous.
        load       = !q_empty;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (load) begin
      len_nxt   = q_len;
      dash_nxt  = q_dash;
      elem_nxt  = '0;
      state_nxt = (q_len == '0) ? ST_LETTER_GAP : ST_KEY_ON;
    end
  end

  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= strobe_nxt;
    end
    len_r           <= len_nxt;
    elem_r          <= elem_nxt;
    dash_r          <= dash_nxt;
    out_key_level_r <= level_nxt;
    out_run_ticks_r <= ticks_nxt;
    out_last_run_r  <= last_nxt;
  end

  assign out_strobe    = out_strobe_r;
  assign out_key_level = out_key_level_r;
  assign out_run_ticks = out_run_ticks_r;
  assign out_last_run  = out_last_run_r;

endmodule

@@ tb/sv/morse_symbol_keyer_test.sv @@
// Self-checking testbench for morse_symbol_keyer: drives characters and timing
// registers, predicts every run from its own pattern table and compares.
// Depends on msk_pkg and the morse_symbol_keyer RTL only.
module morse_symbol_keyer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SYMBOL_COUNT = 38;
  localparam int MAX_ELEMENTS = 6;

  localparam int SYM_W     = msk_pkg::SYM_W;
  localparam int TICK_W    = msk_pkg::TICK_W;
  localparam int CFG_IDX_W = msk_pkg::CFG_IDX_W;

  // Cycles allowed for characters that produce no runs to clear the lookup
  // and the two-entry queue before the timing registers are touched.
  localparam int SETTLE_CYCLES = 20;
  // Cycles with no transfer of any kind before the run is declared hung.
  localparam int HANG_LIMIT = 2000;

  localparam logic KEY_ON  = 1'b1;
  localparam logic KEY_OFF = 1'b0;

  // Pattern of each character: length in the top nibble, and in the low
  // byte bit i set when element i is a dash. Several entries depart from
  // standard Morse on purpose, and some repeat one another.
  localparam logic [11:0] PATTERNS [SYMBOL_COUNT] = '{
    12'h202, 12'h401, 12'h306, 12'h301, 12'h100, 12'h404,
    12'h303, 12'h400, 12'h200, 12'h40E, 12'h305, 12'h402,
    12'h203, 12'h201, 12'h307, 12'h406, 12'h40B, 12'h302,
    12'h300, 12'h101, 12'h304, 12'h404, 12'h408, 12'h306,
    12'h409, 12'h40D, 12'h403, 12'h40A, 12'h405, 12'h407,
    12'h403, 12'h504, 12'h600, 12'h60C, 12'h635, 12'h509,
    12'h50D, 12'h62D
  };

  // Directed characters: the shortest and longest patterns, the first and
  // last positions, a pattern of all dots, and positions outside the set
  // (including the top of the six-bit field) mixed in between.
  localparam logic [SYM_W-1:0] DIRECTED [16] = '{
    6'd0, 6'd4, 6'd19, 6'd38, 6'd32, 6'd33, 6'd34, 6'd37,
    6'd63, 6'd36, 6'd9, 6'd16, 6'd25, 6'd1, 6'd42, 6'd35
  };

  typedef struct {
    logic              key_level;
    logic [TICK_W-1:0] run_ticks;
    logic              last_run;
  } keyed_run_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [SYM_W-1:0]     in_symbol_index = '0;
  logic                 out_strobe;
  logic                 out_key_level;
  logic [TICK_W-1:0]    out_run_ticks;
  logic                 out_last_run;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TICK_W-1:0]    cfg_data = '0;

  // Our own copy of the timing registers, starting from their reset values.
  logic [TICK_W-1:0] dot_len        = 16'd200;
  logic [TICK_W-1:0] dash_len       = 16'd600;
  logic [TICK_W-1:0] elem_gap_len   = 16'd200;
  logic [TICK_W-1:0] letter_gap_len = 16'd600;

  logic [SYM_W-1:0] symbol_queue [$];   // characters waiting to be sent
  keyed_run_t       run_queue [$];      // runs still owed by the keyer

  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned idle_cycles = 0;
  int          mismatches = 0;

  morse_symbol_keyer #(
    .SYMBOL_COUNT(SYMBOL_COUNT),
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_symbol_index(in_symbol_index),
    .out_strobe     (out_strobe),
    .out_key_level  (out_key_level),
    .out_run_ticks  (out_run_ticks),
    .out_last_run   (out_last_run),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // Works out the runs that one character causes and queues them in order:
  // a key-on run and an element gap per element, then a letter gap that
  // closes the character. Positions outside the set cause nothing at all.
  task automatic queue_character_runs(input logic [SYM_W-1:0] sym);
    keyed_run_t  run;
    int unsigned count;
    logic [7:0]  dash_bits;
    if (sym >= SYMBOL_COUNT) begin
      return;
    end
    count = PATTERNS[sym][11:8];
    dash_bits = PATTERNS[sym][7:0];
    if (count > MAX_ELEMENTS) begin
      count = MAX_ELEMENTS;
    end
    for (int e = 0; e < count; e++) begin
      run.key_level = KEY_ON;
      run.run_ticks = dash_bits[e] ? dash_len : dot_len;
      run.last_run  = 1'b0;
      run_queue.push_back(run);
      run.key_level = KEY_OFF;
      run.run_ticks = elem_gap_len;
      run_queue.push_back(run);
    end
    run.key_level = KEY_OFF;
    run.run_ticks = letter_gap_len;
    run.last_run  = 1'b1;
    run_queue.push_back(run);
  endtask

  // Character driver. A transfer happens at an edge where start is high and
  // busy is low; the runs are predicted there from the index actually held
  // on the port. The sender works in bursts of random length separated by
  // random gaps, and a gap of zero gives stretches of back-to-back traffic.
  // While no character is offered the index port carries junk.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        queue_character_runs(in_symbol_index);
      end
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          start <= 1'b0;
          in_symbol_index <= SYM_W'($urandom);
        end else if (symbol_queue.size() != 0) begin
          start <= 1'b1;
          in_symbol_index <= symbol_queue.pop_front();
          burst_left = burst_left - 1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(16, 1);
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
          end
        end else begin
          start <= 1'b0;
          in_symbol_index <= SYM_W'($urandom);
        end
      end
    end
  end

  // Run monitor. The keyer cannot be held off, so every strobe is a transfer
  // and is compared field by field with the oldest run still owed.
  always @(posedge clk) begin
    keyed_run_t want;
    if (rst_n && out_strobe) begin
      if (run_queue.size() == 0) begin
        $error("unexpected run: key_level %0d run_ticks %0d last_run %0d",
               out_key_level, out_run_ticks, out_last_run);
        mismatches++;
      end else begin
        want = run_queue.pop_front();
        if (out_key_level !== want.key_level) begin
          $error("key_level: expected %0d, got %0d", want.key_level, out_key_level);
          mismatches++;
        end
        if (out_run_ticks !== want.run_ticks) begin
          $error("run_ticks: expected %0d, got %0d", want.run_ticks, out_run_ticks);
          mismatches++;
        end
        if (out_last_run !== want.last_run) begin
          $error("last_run: expected %0d, got %0d", want.last_run, out_last_run);
          mismatches++;
        end
      end
    end
  end

  // Hang detector: any transfer on any of the three channels restarts it.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= HANG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Writes all four timing registers back to back, holding valid high from
  // one transfer to the next, and mirrors each write into our own copy at
  // the edge where it is taken. Called just after a rising edge.
  task automatic set_timing(input logic [TICK_W-1:0] t_dot, input logic [TICK_W-1:0] t_dash,
                            input logic [TICK_W-1:0] t_egap,
                            input logic [TICK_W-1:0] t_lgap);
    logic [TICK_W-1:0]    values [4];
    logic [CFG_IDX_W-1:0] regs [4];
    values = '{t_dot, t_dash, t_egap, t_lgap};
    regs = '{msk_pkg::REG_DOT, msk_pkg::REG_DASH, msk_pkg::REG_ELEM_GAP,
             msk_pkg::REG_LETTER_GAP};
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[k];
      cfg_data <= values[k];
      do @(posedge clk); while (!cfg_ready);
      case (cfg_index)
        msk_pkg::REG_DOT:        dot_len = cfg_data;
        msk_pkg::REG_DASH:       dash_len = cfg_data;
        msk_pkg::REG_ELEM_GAP:   elem_gap_len = cfg_data;
        msk_pkg::REG_LETTER_GAP: letter_gap_len = cfg_data;
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Waits until every character has been sent and every run has arrived,
  // then lets the keyer clear any trailing characters that produce no runs.
  // Ends just after a rising edge, ready for a register write.
  task automatic wait_drained();
    while (symbol_queue.size() != 0 || start || run_queue.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Queues a number of characters from the set with occasional positions
  // outside it; the latter are not counted, as the keyer ignores them.
  task automatic load_random(input int count);
    int loaded;
    loaded = 0;
    @(negedge clk);
    while (loaded < count) begin
      if ($urandom_range(6) == 0) begin
        symbol_queue.push_back(SYM_W'($urandom_range(63, SYMBOL_COUNT)));
      end else begin
        symbol_queue.push_back(SYM_W'($urandom_range(SYMBOL_COUNT - 1, 0)));
        loaded++;
      end
    end
  endtask

  // Timing values for the random phases, leaning on the extremes and on a
  // zero duration, which the keyer must pass through unchanged.
  function automatic logic [TICK_W-1:0] pick_ticks();
    case ($urandom_range(7))
      0: return '0;
      1: return 16'd1;
      2: return 16'hFFFF;
      default: return TICK_W'($urandom);
    endcase
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed characters at the reset timing, before any register write.
    @(negedge clk);
    foreach (DIRECTED[i]) begin
      symbol_queue.push_back(DIRECTED[i]);
    end
    wait_drained();

    // Zero-length runs, then the largest durations, then mixed extremes.
    set_timing('0, '0, '0, '0);
    @(negedge clk);
    symbol_queue.push_back(6'd34);
    symbol_queue.push_back(6'd4);
    symbol_queue.push_back(6'd51);
    wait_drained();

    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    @(negedge clk);
    symbol_queue.push_back(6'd37);
    symbol_queue.push_back(6'd19);
    wait_drained();

    set_timing(16'd1, 16'hFFFF, 16'd1, 16'hFFFF);
    @(negedge clk);
    symbol_queue.push_back(6'd33);
    symbol_queue.push_back(6'd0);
    wait_drained();

    // Random phases. Each stops half way and lets the keyer drain fully
    // before sending the second half, so the sender pauses with nothing owed.
    for (int phase = 0; phase < 4; phase++) begin
      set_timing(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks());
      load_random(10);
      wait_drained();
      load_random(10);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/msk_pkg.sv
rtl/msk_front.sv
rtl/msk_fifo.sv
rtl/msk_back.sv
rtl/morse_symbol_keyer.sv
tb/sv/morse_symbol_keyer_test.sv
